>>> rtl/kld_pkg.sv
// Package for the weighted KL divergence accumulator.
// Holds payload structs, controller/datapath command types and arithmetic constants.
// No dependencies.
package kld_pkg;

   // fixed point format of the element fields
   localparam int FRACTION_BITS = 16;

   // log2 recurrence: fraction bits and squaring steps
   localparam int LOG_FRAC = 28;
   localparam int LOG_CNT_W = $clog2(LOG_FRAC);

   // ln2 in Q30 and the shift that brings the log difference to FRACTION_BITS
   localparam logic [63:0] LN2_Q30 = 64'd744261118;
   localparam int LN_SH = LOG_FRAC + 30 - FRACTION_BITS;

   // magnitude of L after scaling: below 2^(5+FRACTION_BITS)
   localparam int LMAG_W = FRACTION_BITS + 6;

   // serial multiplier: 64 x 64 operands, one byte of B per step
   localparam int MUL_STEPS = 8;
   localparam int MUL_CNT_W = 4;

   typedef struct packed {
      logic signed [31:0] argument;
      logic signed [31:0] reference;
      logic signed [31:0] domain_weight;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic signed [31:0] derivative;
      logic signed [47:0] divergence_total;
      logic               last_out;
      logic               bad_argument;
      logic               saturated;
   } rsp_type;

   // multiplications done in turn per item
   typedef enum logic [1:0] {
      OP_LN   = 2'd0,
      OP_DER  = 2'd1,
      OP_XL   = 2'd2,
      OP_TERM = 2'd3
   } op_type;

   typedef struct packed {
      logic   load;
      logic   log_step;
      logic   mul_load;
      logic   mul_step;
      logic   mul_store;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> rtl/kld_ifs.sv
// Valid/ready channel interfaces for request and response items.
// Depends on kld_pkg for the payload structs.
interface kld_req_if;
   logic             valid;
   logic             ready;
   kld_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface kld_rsp_if;
   logic             valid;
   logic             ready;
   kld_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/kld_ctrl.sv
// Sequencer for the KL divergence accumulator: accept, log recurrence,
// four serial multiplications, emit. Depends on kld_pkg.
module kld_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kld_pkg::status_type status,
   output kld_pkg::cmd_type    cmd
);
   import kld_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOG  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam int CNT_W = (LOG_CNT_W > MUL_CNT_W) ? LOG_CNT_W : MUL_CNT_W;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   op_type            op_ff, op_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOG;
               cnt_in   = '0;
            end
         end
         ST_LOG: begin
            cmd.log_step = 1'b1;
            if (cnt_ff == CNT_W'(LOG_FRAC - 1)) begin
               state_in = ST_MUL;
               cnt_in   = '0;
               op_in    = OP_LN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            // count 0 loads operands, then one step per byte, then store
            if (cnt_ff == '0) begin
               cmd.mul_load = 1'b1;
            end else if (cnt_ff <= CNT_W'(MUL_STEPS)) begin
               cmd.mul_step = 1'b1;
            end else begin
               cmd.mul_store = 1'b1;
            end
            if (cnt_ff == CNT_W'(MUL_STEPS + 1)) begin
               cnt_in = '0;
               case (op_ff)
                  OP_LN:   op_in = OP_DER;
                  OP_DER:  op_in = OP_XL;
                  OP_XL:   op_in = OP_TERM;
                  default: state_in = ST_EMIT;
               endcase
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         op_ff    <= OP_LN;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
      end
   end

endmodule

>>> rtl/kld_dpath.sv
// Datapath of the KL divergence accumulator: operand registers, two log2
// squaring units, a byte-serial multiplier, running sum and output register.
// Depends on kld_pkg.
module kld_dpath (
   input  logic                clock,
   input  logic                reset,
   input  kld_pkg::cmd_type    cmd,
   output kld_pkg::status_type status,
   input  kld_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output kld_pkg::rsp_type    rsp_data
);
   import kld_pkg::*;

   localparam int F = FRACTION_BITS;

   // element registers
   logic signed [31:0] x_ff, r_ff;
   logic [31:0]        wmag_ff;
   logic               last_ff, bad_ff;
   logic [63:0]        w2_ff;

   // log2 state for argument and reference
   logic [4:0]          px_ff, pr_ff;
   logic [31:0]         mx_ff, mr_ff;
   logic [LOG_FRAC-1:0] fx_ff, fr_ff;

   // serial multiplier
   logic [63:0]  ma_ff, mb_ff;
   logic [135:0] mp_ff;

   // intermediate results
   logic              dneg_ff, lneg_ff;
   logic [LMAG_W-1:0] lmag_ff;
   logic signed [31:0] deriv_ff;
   logic              sat_d_ff, sat_t_ff;
   logic              tneg_ff;
   logic [63:0]       tmag_ff;
   logic signed [47:0] term_ff;

   // accumulator and output
   logic signed [47:0] sum_ff;
   logic               sticky_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // ---- normalization of a raw value for log2 ----
   function automatic logic [4:0] top_bit(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

   logic [31:0] x_in_u, r_in_u;
   logic [4:0]  px_in, pr_in;
   logic        r_nonpos;

   assign x_in_u   = req_data.argument;
   assign r_nonpos = req_data.reference[31] || (req_data.reference == '0);
   assign r_in_u   = r_nonpos ? 32'd1 : req_data.reference;
   assign px_in    = top_bit(x_in_u);
   assign pr_in    = top_bit(r_in_u);

   // ---- one squaring step ----
   logic [63:0] sqx, sqr;
   logic [32:0] msx, msr;
   assign sqx = 64'(mx_ff) * 64'(mx_ff);
   assign sqr = 64'(mr_ff) * 64'(mr_ff);
   assign msx = sqx[63:31];
   assign msr = sqr[63:31];

   // ---- log difference ----
   logic signed [33:0] lx, lr, dval;
   logic [33:0]        dmag;
   assign lx   = $signed({1'b0, px_ff, fx_ff});
   assign lr   = $signed({1'b0, pr_ff, fr_ff});
   assign dval = lx - lr;
   assign dmag = dval[33] ? 34'(-dval) : 34'(dval);

   // ---- multiplier step ----
   logic [71:0]  pp;
   logic [136:0] macc;
   assign pp   = 72'(ma_ff) * 72'(mb_ff[7:0]);
   assign macc = {1'b0, mp_ff} + {1'b0, pp, 64'd0};

   // ---- result stores ----
   logic [127:0] prod;
   logic [127:0] ln_r, der_r, term_r;
   logic [127:0] ln_q, der_q, term_q;
   assign prod   = mp_ff[127:0];
   assign ln_r   = prod + (128'd1 << (LN_SH - 1));
   assign der_r  = prod + (128'd1 << (2 * F - 1));
   assign term_r = prod + (128'd1 << (3 * F - 1));
   assign ln_q   = ln_r >> LN_SH;
   assign der_q  = der_r >> (2 * F);
   assign term_q = term_r >> (3 * F);

   // derivative clip to 32 bits
   logic signed [31:0] deriv_c;
   logic               deriv_sat;
   always_comb begin
      deriv_sat = 1'b0;
      if (lneg_ff) begin
         if (der_q > 128'h8000_0000) begin
            deriv_sat = 1'b1;
            deriv_c   = 32'sh8000_0000;
         end else begin
            deriv_c = 32'(-der_q[31:0]);
         end
      end else if (der_q > 128'h7FFF_FFFF) begin
         deriv_sat = 1'b1;
         deriv_c   = 32'sh7FFF_FFFF;
      end else begin
         deriv_c = der_q[31:0];
      end
   end

   // term clip to 48 bits
   logic signed [47:0] term_c;
   logic               term_sat;
   always_comb begin
      term_sat = 1'b0;
      if (tneg_ff) begin
         if (term_q > (128'd1 << 47)) begin
            term_sat = 1'b1;
            term_c   = {1'b1, 47'd0};
         end else begin
            term_c = 48'(-term_q[47:0]);
         end
      end else if (term_q > ((128'd1 << 47) - 128'd1)) begin
         term_sat = 1'b1;
         term_c   = {1'b0, {47{1'b1}}};
      end else begin
         term_c = term_q[47:0];
      end
   end

   // t = x*L + (r - x)*2^F
   logic signed [32:0] rmx;
   logic signed [63:0] rs, xl_s, tval;
   assign rmx  = 33'(r_ff) - 33'(x_ff);
   assign rs   = 64'(rmx) <<< F;
   assign xl_s = lneg_ff ? -$signed(prod[63:0]) : $signed(prod[63:0]);
   assign tval = xl_s + rs;

   // running sum with clip
   logic signed [48:0] sum_w;
   logic signed [47:0] sum_c;
   logic               sum_sat, sat_all;
   assign sum_w = 49'(sum_ff) + 49'(term_ff);
   always_comb begin
      sum_sat = 1'b0;
      sum_c   = sum_w[47:0];
      if (sum_w[48] != sum_w[47]) begin
         sum_sat = 1'b1;
         sum_c   = sum_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
   end
   assign sat_all = sticky_ff | sat_d_ff | sat_t_ff | sum_sat;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_data.argument;
         r_ff    <= $signed(r_in_u);
         wmag_ff <= req_data.domain_weight[31] ? 32'(-req_data.domain_weight)
                                               : req_data.domain_weight;
         last_ff <= req_data.last_element;
         bad_ff  <= req_data.argument[31] || (req_data.argument == '0);
         px_ff   <= px_in;
         pr_ff   <= pr_in;
         mx_ff   <= x_in_u << (5'd31 - px_in);
         mr_ff   <= r_in_u << (5'd31 - pr_in);
         fx_ff   <= '0;
         fr_ff   <= '0;
      end
      if (cmd.log_step) begin
         w2_ff <= 64'(wmag_ff) * 64'(wmag_ff);
         mx_ff <= msx[32] ? msx[32:1] : msx[31:0];
         mr_ff <= msr[32] ? msr[32:1] : msr[31:0];
         fx_ff <= {fx_ff[LOG_FRAC-2:0], msx[32]};
         fr_ff <= {fr_ff[LOG_FRAC-2:0], msr[32]};
      end
      if (cmd.mul_load) begin
         mp_ff <= '0;
         case (cmd.op)
            OP_LN: begin
               ma_ff   <= 64'(dmag);
               mb_ff   <= LN2_Q30;
               dneg_ff <= dval[33];
            end
            OP_DER: begin
               ma_ff <= w2_ff;
               mb_ff <= 64'(lmag_ff);
            end
            OP_XL: begin
               ma_ff <= 64'($unsigned(x_ff));
               mb_ff <= 64'(lmag_ff);
            end
            default: begin
               ma_ff <= w2_ff;
               mb_ff <= tmag_ff;
            end
         endcase
      end
      if (cmd.mul_step) begin
         mp_ff <= {7'd0, macc[136:8]};
         mb_ff <= mb_ff >> 8;
      end
      if (cmd.mul_store) begin
         case (cmd.op)
            OP_LN: begin
               lmag_ff <= bad_ff ? '0 : ln_q[LMAG_W-1:0];
               lneg_ff <= dneg_ff & !bad_ff;
            end
            OP_DER: begin
               deriv_ff <= deriv_c;
               sat_d_ff <= deriv_sat;
            end
            OP_XL: begin
               tneg_ff <= tval[63];
               tmag_ff <= tval[63] ? 64'(-tval) : 64'(tval);
            end
            default: begin
               term_ff  <= term_c;
               sat_t_ff <= term_sat;
            end
         endcase
      end
      if (cmd.emit) begin
         rsp_ff.derivative       <= deriv_ff;
         rsp_ff.divergence_total <= last_ff ? sum_c : '0;
         rsp_ff.last_out         <= last_ff;
         rsp_ff.bad_argument     <= bad_ff;
         rsp_ff.saturated        <= sat_all;
      end
   end

   // accumulator and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            sum_ff       <= last_ff ? '0 : sum_c;
            sticky_ff    <= last_ff ? 1'b0 : sat_all;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> rtl/weighted_kl_divergence_accumulate.sv
// Top level of the weighted KL divergence accumulator.
// Joins kld_ctrl and kld_dpath; uses kld_pkg and the kld_req_if/kld_rsp_if channels.
//
//   channel    direction  contents
//   req_chan   in         argument, reference, domain_weight, last_element
//   rsp_chan   out        derivative, divergence_total, last_out, bad_argument, saturated
//
// An item passes through an accept step, 28 log2 squaring steps (argument and
// reference in parallel), then four multiplications on the byte-serial
// multiplier, then an emit step. The squaring recurrence and the shared
// multiplier set how long an item takes. Reset (synchronous) clears the running
// sum and sticky saturation. A stalled result sits in the output register;
// the next item is accepted meanwhile and waits only at its own emit cycle.
module weighted_kl_divergence_accumulate (
   input logic            clock,
   input logic            reset,
   kld_req_if.sink        req_chan,
   kld_rsp_if.source      rsp_chan
);
   import kld_pkg::*;

   cmd_type    cmd;
   status_type status;

   kld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kld_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_chan.data),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_chan.data)
   );

endmodule

>>> verif/kld_scoreboard.sv
// Scoreboard for the weighted KL divergence accumulator: predicts each result
// from the accepted item and checks results in order. Depends on kld_pkg.
package kld_scoreboard_pkg;
   import kld_pkg::*;

   class kld_scoreboard;
      rsp_type     pending_rsp[$];
      logic signed [47:0] acc_sum;
      bit          acc_sat;
      int          mismatches;
      int          checked;

      function new();
         acc_sum = '0;
         acc_sat = 1'b0;
         mismatches = 0;
         checked = 0;
      endfunction

      // log2 of v >= 1 scaled by 2^LOG_FRAC, squaring recurrence
      function automatic longint log2_q28(logic [31:0] v);
         int p;
         logic [63:0] m;
         longint fr;
         p = 31;
         fr = 0;
         while (p > 0 && v[p] == 1'b0) p--;
         m = 64'(v) << (31 - p);
         for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
               m = m >> 1;
               fr = fr | (longint'(1) << i);
            end
         end
         return (longint'(p) << LOG_FRAC) + fr;
      endfunction

      // round(a*b/2^s) ties away, capped at 2^62
      function automatic logic [63:0] round_product(logic [63:0] a, logic [63:0] b, int s);
         logic [127:0] prod;
         prod = 128'(a) * 128'(b);
         prod = (prod + (128'd1 << (s - 1))) >> s;
         if (prod > (128'd1 << 62)) return 64'd1 << 62;
         return prod[63:0];
      endfunction

      function automatic longint saturate(bit neg, logic [63:0] mag, int bits, ref bit sat);
         logic [63:0] lim;
         lim = 64'd1 << (bits - 1);
         if (neg) begin
            if (mag > lim) begin
               sat = 1'b1;
               return -longint'(lim);
            end
            return -longint'(mag);
         end
         if (mag > lim - 1) begin
            sat = 1'b1;
            return longint'(lim - 1);
         end
         return longint'(mag);
      endfunction

      // note an accepted item and queue its expected result
      function void note_element(req_type it);
         longint x, r, w, lval, t, d, sum, lim;
         logic [63:0] wm, w2, dm, pm, mag;
         bit bad, sat;
         rsp_type e;
         x = it.argument;
         r = it.reference;
         w = it.domain_weight;
         bad = (x <= 0);
         sat = 1'b0;
         wm = (w < 0) ? -w : w;
         w2 = wm * wm;
         lval = 0;
         if (r <= 0) r = 1;
         if (!bad) begin
            d = log2_q28(x[31:0]) - log2_q28(r[31:0]);
            dm = (d < 0) ? -d : d;
            pm = (dm * LN2_Q30 + (64'd1 << (LN_SH - 1))) >> LN_SH;
            lval = (d < 0) ? -longint'(pm) : longint'(pm);
         end
         mag = round_product(w2, (lval < 0) ? -lval : lval, 2 * FRACTION_BITS);
         e.derivative = 32'(saturate(lval < 0, mag, 32, sat));
         t = (bad ? 0 : x * lval) + (r - x) * (longint'(1) << FRACTION_BITS);
         mag = round_product(w2, (t < 0) ? -t : t, 3 * FRACTION_BITS);
         lim = longint'(1) << 47;
         sum = longint'(acc_sum) + saturate(t < 0, mag, 48, sat);
         if (sum > lim - 1) begin
            sum = lim - 1;
            sat = 1'b1;
         end else if (sum < -lim) begin
            sum = -lim;
            sat = 1'b1;
         end
         acc_sum = 48'(sum);
         acc_sat = acc_sat | sat;
         e.divergence_total = it.last_element ? 48'(sum) : '0;
         e.last_out = it.last_element;
         e.bad_argument = bad;
         e.saturated = acc_sat;
         pending_rsp.push_back(e);
         if (it.last_element) begin
            acc_sum = '0;
            acc_sat = 1'b0;
         end
      endfunction

      // compare one result with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending_rsp.pop_front();
         checked++;
         if (got.derivative !== e.derivative || got.divergence_total !== e.divergence_total ||
             got.last_out !== e.last_out || got.bad_argument !== e.bad_argument ||
             got.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", e, got);
         end
      endfunction
   endclass
endpackage

>>> verif/weighted_kl_divergence_accumulate_test.sv
// Testbench top for weighted_kl_divergence_accumulate: directed and random
// elements with idling phases. Depends on kld_pkg, kld_ifs, kld_scoreboard.
module weighted_kl_divergence_accumulate_test;
   timeunit 1ns;
   timeprecision 1ps;
   import kld_pkg::*;
   import kld_scoreboard_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   kld_req_if req_chan();
   kld_rsp_if rsp_chan();

   weighted_kl_divergence_accumulate dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   kld_scoreboard board;
   int send_idle_pct;
   int stall_pct;
   bit hold_rsp;
   int idle_cycles;
   int sent;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // monitor both channels and the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_element(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) board.check_result(rsp_chan.data);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // returns at the accepting edge; valid drops at the next falling edge
   // unless another item follows right away
   task automatic send_element(logic [31:0] x, logic [31:0] r, logic [31:0] w, bit last);
      req_type it;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      it.argument = x;
      it.reference = r;
      it.domain_weight = w;
      it.last_element = last;
      req_chan.data <= it;
      req_chan.valid <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(32'h0008_0000, 32'h0000_0100);
         2: return $urandom_range(32'h0001_8000, 32'h0000_8000);
         3: return -$urandom_range(32'h0004_0000);
         default: return $urandom_range(32'h0100_0000, 1);
      endcase
   endfunction

   task automatic random_burst(int n);
      for (int i = 0; i < n; i++)
         send_element(rand_val(), rand_val(),
                      ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0002_0000),
                      $urandom_range(7) == 0);
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_rsp = 1'b0;
      idle_cycles = 0;
      sent = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, bad arguments, bad references, saturation
      send_element(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
      send_element(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
      send_element(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1);
      send_element(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_element(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
      send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_element(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
      send_element(32'h0002_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
      send_element(32'h0000_0001, 32'h0000_0001, 32'h0003_0000, 1'b1);
      send_element(32'h0003_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b0);
      send_element(32'h0000_8000, 32'h0002_0000, 32'h0000_0001, 1'b1);
      send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
      drain();

      // idling phases
      random_burst(80);
      send_idle_pct = 74;
      random_burst(80);
      send_idle_pct = 0;
      stall_pct = 74;
      random_burst(80);
      send_idle_pct = 25;
      stall_pct = 25;
      random_burst(80);
      drain();

      // long receiver hold-off while items keep coming
      send_idle_pct = 0;
      stall_pct = 0;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_burst(6);
      join
      drain();
      random_burst(60);
      drain();

      $display("covered %0d elements, %0d results checked, across idle and stall phases",
               sent, board.checked);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/kld_pkg.sv
rtl/kld_ifs.sv
rtl/kld_ctrl.sv
rtl/kld_dpath.sv
rtl/weighted_kl_divergence_accumulate.sv
verif/kld_scoreboard.sv
verif/weighted_kl_divergence_accumulate_test.sv
